// ===== hw/rtl/msl_pkg.sv =====
// msl_pkg.sv: shared constants, field widths and controller/datapath structs
// for the multichannel slew limiter. No dependencies.
package msl_pkg;

	localparam int DEF_MAX_CHANNELS = 16;

	localparam int MODE_W    = 2;
	localparam int CHANNEL_W = 4;
	localparam int LENGTH_W  = 14;
	localparam int DT_W      = 10;
	localparam int POS_W     = 13;
	localparam int TGT_W     = 14;
	localparam int CODE_W    = 12;
	localparam int MORTON_W  = 24;
	localparam int STEP_W    = 17;
	localparam int COUNT_W   = 5;
	localparam int SPEED_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;

	localparam logic [MODE_W-1:0] MODE_PLACE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TARGET = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 1'd1;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd0;
	localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd800;
	localparam logic [CODE_W-1:0]  TELEM_RESET = 12'd2048;

	localparam logic [POS_W-1:0]  POS_MIN  = 13'd4480;
	localparam logic [POS_W-1:0]  POS_MAX  = 13'd6880;
	localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;

	// code = floor(d*4095/2400) = floor(floor(d*273/32)/5)
	localparam logic [19:0] CODE_MUL = 20'd273;
	// exact floor(y/5) for y below 2**16: (y*52429) >> 18
	localparam logic [30:0] DIV5_MUL = 31'd52429;
	// exact floor(z/125) for z below 2**23: (z*8589935) >> 30
	localparam logic [46:0] DIV125_MUL = 47'd8589935;

	typedef struct packed {
		logic capture;
		logic apply;
		logic step_mul;
		logic step_div;
		logic walk;
		logic code0;
		logic code1;
		logic code2;
		logic load_out;
	} msl_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              active_zero;
		logic              walk_last;
	} msl_status_t;

endpackage

// ===== hw/rtl/msl_ram.sv =====
// msl_ram.sv: generic single-write, single-read RAM with registered read data.
// No dependencies.
module msl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/msl_ctrl.sv =====
// msl_ctrl.sv: controller state machine of the slew limiter; sequences capture,
// step calculation, channel walk, code pipeline and result handoff. Uses msl_pkg.
module msl_ctrl
	import msl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  msl_status_t status,
	output msl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_STEP_MUL,
		ST_STEP_DIV,
		ST_WALK,
		ST_CODE0,
		ST_CODE1,
		ST_CODE2,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (status.mode == MODE_TICK) begin
						state_q <= ST_STEP_MUL;
					end else begin
						state_q <= ST_CODE0;
					end
				end
				ST_STEP_MUL: state_q <= ST_STEP_DIV;
				ST_STEP_DIV: begin
					if (status.active_zero) begin
						state_q <= ST_CODE0;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (status.walk_last) begin
						state_q <= ST_CODE0;
					end
				end
				ST_CODE0: state_q <= ST_CODE1;
				ST_CODE1: state_q <= ST_CODE2;
				ST_CODE2: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.capture  = in_valid && in_ready_q;
			ST_DECODE:   cmd.apply    = 1'b1;
			ST_STEP_MUL: cmd.step_mul = 1'b1;
			ST_STEP_DIV: cmd.step_div = 1'b1;
			ST_WALK:     cmd.walk     = 1'b1;
			ST_CODE0:    cmd.code0    = 1'b1;
			ST_CODE1:    cmd.code1    = 1'b1;
			ST_CODE2:    cmd.code2    = 1'b1;
			ST_OUT:      cmd.load_out = !out_valid_q || out_ready;
			default:     cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/msl_datapath.sv =====
// msl_datapath.sv: configuration registers, position/target memories, step
// divider, channel update, code pipeline and result register. Uses msl_pkg, msl_ram.
module msl_datapath
	import msl_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [S_TDATA_W-1:0]  in_data,
	input  logic [S_TUSER_W-1:0]  in_user,
	output logic [M_TDATA_W-1:0]  out_data,
	input  msl_cmd_t              cmd,
	output msl_status_t           status
);

	localparam int AW = $clog2(MAX_CHANNELS);
	localparam int CW = $clog2(MAX_CHANNELS + 1);

	logic [COUNT_W-1:0]   channel_count_q;
	logic [SPEED_W-1:0]   speed_limit_q;
	logic [CODE_W-1:0]    telemetry_q;
	logic [MODE_W-1:0]    mode_q;
	logic [CHANNEL_W-1:0] channel_q;
	logic [LENGTH_W-1:0]  length_q;
	logic [DT_W-1:0]      dt_q;
	logic                 ok_q;
	logic [25:0]          prod_s1;
	logic [STEP_W-1:0]    step_q;
	logic [AW-1:0]        idx_q;
	logic [POS_W-1:0]     pos0_q;
	logic [POS_W-1:0]     pos1_q;
	logic [19:0]          code_s1;
	logic [CODE_W-1:0]    code0_q;
	logic [CODE_W-1:0]    code1_q;
	logic [M_TDATA_W-1:0] out_q;

	logic [CW-1:0]     active_n;
	logic              ch_ok;
	logic              len_ok;
	logic [AW-1:0]     ch_addr;
	logic              pos_we;
	logic [AW-1:0]     pos_waddr;
	logic [POS_W-1:0]  pos_wdata;
	logic              tgt_we;
	logic [AW-1:0]     raddr;
	logic [POS_W-1:0]  pos_rd;
	logic [TGT_W-1:0]  tgt_rd;
	logic [46:0]       div_prod;
	logic [17:0]       pw;
	logic [17:0]       tw;
	logic [17:0]       sw;
	logic [17:0]       moved;
	logic [POS_W-1:0]  new_pos;
	logic [POS_W-1:0]  code_src;
	logic [CODE_W-1:0] code_d;
	logic [19:0]       code_mul;
	logic [30:0]       div5_prod;
	logic [12:0]       code_full;
	logic [CODE_W-1:0] code_sat;
	logic [CODE_W-1:0] telem_next;
	logic [MORTON_W-1:0] morton;

	function automatic logic [MORTON_W-1:0] interleave(input logic [CODE_W-1:0] a,
			input logic [CODE_W-1:0] b);
		logic [MORTON_W-1:0] m;
		m = '0;
		for (int i = 0; i < CODE_W; i++) begin
			m[2*i]   = a[i];
			m[2*i+1] = b[i];
		end
		return m;
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= COUNT_RESET;
			speed_limit_q   <= SPEED_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[COUNT_W-1:0];
				REG_SPEED_LIMIT:   speed_limit_q   <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	assign active_n = (32'(channel_count_q) > MAX_CHANNELS) ? CW'(MAX_CHANNELS)
		: CW'(channel_count_q);

	assign status.mode        = mode_q;
	assign status.active_zero = (active_n == '0);
	assign status.walk_last   = ((32'(idx_q) + 32'd1) == 32'(active_n));

	// item decode
	assign ch_ok   = (32'(channel_q) < MAX_CHANNELS);
	assign len_ok  = (length_q >= LENGTH_W'(POS_MIN)) && (length_q <= LENGTH_W'(POS_MAX));
	assign ch_addr = AW'(channel_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			channel_q <= in_data[3:0];
			length_q  <= in_data[17:4];
			dt_q      <= in_data[27:18];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLACE;
			ok_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				mode_q <= in_user;
			end
			if (cmd.apply) begin
				case (mode_q)
					MODE_PLACE:  ok_q <= ch_ok && len_ok;
					MODE_TARGET: ok_q <= ch_ok;
					MODE_TICK:   ok_q <= 1'b1;
					default:     ok_q <= 1'b0;
				endcase
			end
		end
	end

	// step = floor(speed*dt/1000)
	assign div_prod = 47'(prod_s1[25:3]) * DIV125_MUL;

	always_ff @(posedge clk) begin
		if (cmd.step_mul) begin
			prod_s1 <= 26'(speed_limit_q) * 26'(dt_q);
		end
		if (cmd.step_div) begin
			step_q <= div_prod[46:30];
		end
	end

	// channel walk
	always_ff @(posedge clk) begin
		if (cmd.step_div) begin
			idx_q <= '0;
		end else if (cmd.walk) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	assign raddr = cmd.walk ? (idx_q + AW'(1)) : '0;

	assign pw = 18'(pos_rd);
	assign tw = 18'(tgt_rd);
	assign sw = 18'(step_q);

	always_comb begin
		if (tw >= pw) begin
			moved = ((tw - pw) <= sw) ? tw : (pw + sw);
		end else begin
			moved = ((pw - tw) <= sw) ? tw : (pw - sw);
		end
		if (moved < 18'(POS_MIN)) begin
			new_pos = POS_MIN;
		end else if (moved > 18'(POS_MAX)) begin
			new_pos = POS_MAX;
		end else begin
			new_pos = moved[POS_W-1:0];
		end
	end

	assign pos_we    = cmd.walk || (cmd.apply && mode_q == MODE_PLACE && ch_ok && len_ok);
	assign pos_waddr = cmd.walk ? idx_q : ch_addr;
	assign pos_wdata = cmd.walk ? new_pos : length_q[POS_W-1:0];
	assign tgt_we    = cmd.apply && ch_ok && (mode_q == MODE_PLACE ? len_ok
		: mode_q == MODE_TARGET);

	msl_ram #(
		.WIDTH(POS_W),
		.DEPTH(MAX_CHANNELS)
	) u_pos_ram (
		.clk  (clk),
		.we   (pos_we),
		.waddr(pos_waddr),
		.wdata(pos_wdata),
		.raddr(raddr),
		.rdata(pos_rd)
	);

	msl_ram #(
		.WIDTH(TGT_W),
		.DEPTH(MAX_CHANNELS)
	) u_tgt_ram (
		.clk  (clk),
		.we   (tgt_we),
		.waddr(ch_addr),
		.wdata(length_q),
		.raddr(raddr),
		.rdata(tgt_rd)
	);

	// copies of channels 0 and 1 for telemetry and interleave
	always_ff @(posedge clk) begin
		if (pos_we && pos_waddr == AW'(0)) begin
			pos0_q <= pos_wdata;
		end
		if (pos_we && pos_waddr == AW'(1)) begin
			pos1_q <= pos_wdata;
		end
	end

	// code pipeline
	assign code_src  = cmd.code0 ? pos0_q : pos1_q;
	assign code_d    = (code_src > POS_MIN) ? CODE_W'(code_src - POS_MIN) : '0;
	assign code_mul  = 20'(code_d) * CODE_MUL;
	assign div5_prod = 31'(code_s1[19:5]) * DIV5_MUL;
	assign code_full = div5_prod[30:18];
	assign code_sat  = (code_full > 13'(CODE_MAX)) ? CODE_MAX : code_full[CODE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.code0 || cmd.code1) begin
			code_s1 <= code_mul;
		end
		if (cmd.code1) begin
			code0_q <= code_sat;
		end
		if (cmd.code2) begin
			code1_q <= code_sat;
		end
	end

	// result
	assign telem_next = (mode_q == MODE_TICK && !status.active_zero) ? code0_q : telemetry_q;
	assign morton     = (32'(active_n) >= 32'd2) ? interleave(code0_q, code1_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			telemetry_q <= TELEM_RESET;
		end else if (cmd.load_out) begin
			telemetry_q <= telem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= {3'b000, morton, telem_next, ok_q};
		end
	end

	assign out_data = out_q;

endmodule

// ===== hw/rtl/multichannel_slew_limiter.sv =====
// multichannel_slew_limiter.sv: top level of the multichannel slew limiter.
// Joins msl_ctrl and msl_datapath; uses msl_pkg.
//
// channel   handshake                    payload
// s_axis    s_axis_tvalid/s_axis_tready  tuser mode; tdata channel, length, dt_ms
// m_axis    m_axis_tvalid/m_axis_tready  tdata accepted, stroke_code, morton_index
// cfg       cfg_we                       cfg_index, cfg_data
//
// place, set target and rejected items go through decode, the code pipeline and the
// output state before the next accept; a tick adds the step multiply and divide and
// a walk through the position and target memories one channel per cycle
// a stalled result waits in the output register and the next item is taken meanwhile
// after reset: channel_count 0, speed_limit 800, telemetry code 2048; no clearing pass
module multichannel_slew_limiter
	import msl_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // channel, length, dt_ms
	input  logic [S_TUSER_W-1:0]  s_axis_tuser,  // mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_TDATA_W-1:0]  m_axis_tdata   // accepted, stroke_code, morton_index
);

	msl_cmd_t    cmd;
	msl_status_t status;

	msl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	msl_datapath #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_data (m_axis_tdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

// ===== test/tb_multichannel_slew_limiter.sv =====
// tb_multichannel_slew_limiter.sv: self-checking testbench for the multichannel slew limiter.
// Typed table rows carry their expected results; the rest use a built-in actuator predictor.
// Depends on msl_pkg and multichannel_slew_limiter.
module tb_multichannel_slew_limiter;
	import msl_pkg::*;

	localparam int NUM_CH = DEF_MAX_CHANNELS;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam int NUM_PHASES = 9;
	localparam int SPEED_ANY = -1;
	localparam int PH_COUNT [NUM_PHASES] = '{16, 2, 1, 31, 0, 5, 17, 16, 3};
	localparam int PH_SPEED [NUM_PHASES] = '{800, 65535, 0, 4000, 12000, SPEED_ANY, 50,
		SPEED_ANY, 1500};
	localparam int PH_ITEMS [NUM_PHASES] = '{200, 150, 100, 150, 80, 150, 150, 150, 200};

	typedef struct packed {
		logic              accepted;
		logic [CODE_W-1:0]   stroke_code;
		logic [MORTON_W-1:0] morton_index;
	} slew_result_t;

	typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] cfg_reg;
		logic [MODE_W-1:0]    mode;
		logic [CHANNEL_W-1:0] chan;
		logic [15:0]          value;
		logic [DT_W-1:0]      dt;
		slew_result_t         want;
	} plan_row_t;

	localparam int PLAN_LEN = 28;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// empty tick, unused mode, out-of-range placements
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_TICK, 4'd0, 16'd0, 10'd1023, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_UNUSED, 4'd9, 16'd16383, 10'd512,
			'{1'b0, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd0, 16'd4479, 10'd0, '{1'b0, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd0, 16'd6881, 10'd0, '{1'b0, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd15, 16'd16383, 10'd0, '{1'b0, 12'd2048, 24'd0}},
		// place every channel
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd0, 16'd4480, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd1, 16'd6880, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd2, 16'd5000, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd3, 16'd5321, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd4, 16'd6100, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd5, 16'd4481, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd6, 16'd6879, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd7, 16'd5680, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd8, 16'd4800, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd9, 16'd6555, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd10, 16'd5999, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd11, 16'd4700, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd12, 16'd6400, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd13, 16'd5200, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd14, 16'd6000, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_PLACE, 4'd15, 16'd6880, 10'd0, '{1'b1, 12'd2048, 24'd0}},
		// count beyond the channel limit, top speed
		'{ROW_CFG, REG_CHANNEL_COUNT, MODE_PLACE, 4'd0, 16'd31, 10'd0, '{1'b0, 12'd0, 24'd0}},
		'{ROW_CFG, REG_SPEED_LIMIT, MODE_PLACE, 4'd0, 16'd65535, 10'd0, '{1'b0, 12'd0, 24'd0}},
		// target far above range, then a full-range move clamped at the top
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_TARGET, 4'd0, 16'd16383, 10'd0,
			'{1'b1, 12'd2048, 24'hAAAAAA}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_TICK, 4'd0, 16'd0, 10'd1023,
			'{1'b1, 12'd4095, 24'hFFFFFF}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_TARGET, 4'd0, 16'd0, 10'd0,
			'{1'b1, 12'd4095, 24'hFFFFFF}},
		'{ROW_ITEM, REG_CHANNEL_COUNT, MODE_TICK, 4'd5, 16'd100, 10'd0, '{1'b0, 12'd0, 24'd0}},
		'{ROW_TYPED, REG_CHANNEL_COUNT, MODE_TICK, 4'd0, 16'd0, 10'd1023,
			'{1'b1, 12'd0, 24'hAAAAAA}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;  // channel, length, dt_ms
	logic [S_TUSER_W-1:0]  s_axis_tuser;  // mode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;  // accepted, stroke_code, morton_index

	multichannel_slew_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [POS_W-1:0]   act_pos [NUM_CH];
	logic [TGT_W-1:0]   act_tgt [NUM_CH];
	logic [CODE_W-1:0]  telem_code;
	logic [COUNT_W-1:0] cfg_count;
	logic [SPEED_W-1:0] cfg_speed;

	slew_result_t pending_reports [$];
	int unsigned  err_count = 0;
	int unsigned  n_items = 0;
	int unsigned  n_rejected = 0;
	int unsigned  n_ticks = 0;
	int unsigned  n_settings = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  gap_pct = 0;
	int unsigned  stall_pct = 0;
	int unsigned  stall_left = 0;

	function automatic int unsigned stroke_of(int unsigned p);
		int unsigned c;
		if (p <= 32'(POS_MIN))
			return 0;
		c = (p - 32'(POS_MIN)) * 32'(CODE_MAX) / (32'(POS_MAX) - 32'(POS_MIN));
		return (c > 32'(CODE_MAX)) ? 32'(CODE_MAX) : c;
	endfunction

	function automatic logic [MORTON_W-1:0] weave(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
		logic [MORTON_W-1:0] m;
		m = '0;
		for (int i = 0; i < CODE_W; i++) begin
			m[2*i] = a[i];
			m[2*i+1] = b[i];
		end
		return m;
	endfunction

	function automatic slew_result_t advance_actuators(logic [MODE_W-1:0] mode,
		logic [CHANNEL_W-1:0] ch, logic [LENGTH_W-1:0] len, logic [DT_W-1:0] dt);
		slew_result_t r;
		int unsigned  n, step, p, t;
		n = (32'(cfg_count) > NUM_CH) ? NUM_CH : 32'(cfg_count);
		r = '0;
		case (mode)
			MODE_PLACE: begin
				if (len >= LENGTH_W'(POS_MIN) && len <= LENGTH_W'(POS_MAX)) begin
					act_pos[ch] = len[POS_W-1:0];
					act_tgt[ch] = len;
					r.accepted = 1'b1;
				end
			end
			MODE_TARGET: begin
				act_tgt[ch] = len;
				r.accepted = 1'b1;
			end
			MODE_TICK: begin
				step = (32'(cfg_speed) * 32'(dt)) / 1000;
				for (int i = 0; i < n; i++) begin
					p = 32'(act_pos[i]);
					t = 32'(act_tgt[i]);
					if (t >= p)
						p = (t - p <= step) ? t : p + step;
					else
						p = (p - t <= step) ? t : p - step;
					if (p < 32'(POS_MIN))
						p = 32'(POS_MIN);
					if (p > 32'(POS_MAX))
						p = 32'(POS_MAX);
					act_pos[i] = p[POS_W-1:0];
				end
				if (n > 0)
					telem_code = CODE_W'(stroke_of(32'(act_pos[0])));
				r.accepted = 1'b1;
			end
			default: r.accepted = 1'b0;
		endcase
		r.stroke_code = telem_code;
		if (n >= 2)
			r.morton_index = weave(CODE_W'(stroke_of(32'(act_pos[0]))),
				CODE_W'(stroke_of(32'(act_pos[1]))));
		return r;
	endfunction

	task automatic send_item(logic [MODE_W-1:0] mode, logic [CHANNEL_W-1:0] ch,
		logic [LENGTH_W-1:0] len, logic [DT_W-1:0] dt, bit typed, slew_result_t want);
		slew_result_t pred;
		@(negedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, dt, len, ch};
		s_axis_tuser <= mode;
		do @(posedge clk); while (!s_axis_tready);
		pred = advance_actuators(mode, ch, len, dt);
		pending_reports.push_back(typed ? want : pred);
		n_items++;
		if (!pred.accepted)
			n_rejected++;
		if (mode == MODE_TICK)
			n_ticks++;
	endtask

	task automatic drain_reports();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain_reports();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CHANNEL_COUNT)
			cfg_count = val[COUNT_W-1:0];
		else
			cfg_speed = val[SPEED_W-1:0];
	endtask

	task automatic random_item();
		logic [MODE_W-1:0]    mode;
		logic [CHANNEL_W-1:0] ch;
		logic [LENGTH_W-1:0]  len;
		logic [DT_W-1:0]      dt;
		int unsigned          r;
		r = $urandom_range(0, 99);
		ch = CHANNEL_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 1)
			: $urandom_range(0, NUM_CH - 1));
		len = LENGTH_W'($urandom_range(0, 16383));
		dt = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
			: DT_W'($urandom_range(0, 1023));
		if (r < 4) begin
			mode = MODE_UNUSED;
		end else if (r < 38) begin
			mode = MODE_PLACE;
			case ($urandom_range(0, 9))
				0: len = LENGTH_W'($urandom_range(0, 16383));
				1: len = LENGTH_W'($urandom_range(0, 1) ? 32'(POS_MIN) - $urandom_range(0, 1)
					: 32'(POS_MAX) + $urandom_range(0, 1));
				default: len = LENGTH_W'($urandom_range(32'(POS_MIN), 32'(POS_MAX)));
			endcase
		end else if (r < 62) begin
			mode = MODE_TARGET;
			if ($urandom_range(0, 4) != 0)
				len = LENGTH_W'($urandom_range(32'(POS_MIN) - 300, 32'(POS_MAX) + 300));
		end else begin
			mode = MODE_TICK;
		end
		send_item(mode, ch, len, dt, 1'b0, '0);
	endtask

	// result checker and watchdog
	always @(posedge clk) begin
		slew_result_t got, want;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_reports.size());
			$display("multichannel_slew_limiter verification failed");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.accepted = m_axis_tdata[0];
			got.stroke_code = m_axis_tdata[12:1];
			got.morton_index = m_axis_tdata[36:13];
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected item, got %p", $time, got);
				err_count++;
			end else begin
				want = pending_reports.pop_front();
				if (got.accepted !== want.accepted) begin
					$display("%0t: accepted expected %0d got %0d", $time, want.accepted,
						got.accepted);
					err_count++;
				end
				if (got.stroke_code !== want.stroke_code) begin
					$display("%0t: stroke_code expected %0d got %0d", $time, want.stroke_code,
						got.stroke_code);
					err_count++;
				end
				if (got.morton_index !== want.morton_index) begin
					$display("%0t: morton_index expected %h got %h", $time, want.morton_index,
						got.morton_index);
					err_count++;
				end
			end
		end
	end

	// result sink with random stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			m_axis_tready <= 1'b0;
			stall_left = $urandom_range(0, 18);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		int spd;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_count = COUNT_RESET;
		cfg_speed = SPEED_RESET;
		telem_code = TELEM_RESET;
		for (int i = 0; i < NUM_CH; i++) begin
			act_pos[i] = '0;
			act_tgt[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		gap_pct = 20;
		stall_pct = 10;
		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				write_reg(PLAN[i].cfg_reg, PLAN[i].value);
				n_settings++;
			end else begin
				send_item(PLAN[i].mode, PLAN[i].chan, PLAN[i].value[LENGTH_W-1:0], PLAN[i].dt,
					PLAN[i].kind == ROW_TYPED, PLAN[i].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			spd = (PH_SPEED[ph] == SPEED_ANY) ? $urandom_range(0, 65535) : PH_SPEED[ph];
			write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(PH_COUNT[ph]));
			write_reg(REG_SPEED_LIMIT, CFG_DATA_W'(spd));
			n_settings++;
			// no random input gaps or output stalls in the closing phase
			gap_pct = (ph == NUM_PHASES - 1) ? 0 : $urandom_range(0, 30);
			stall_pct = (ph == NUM_PHASES - 1) ? 0 : $urandom_range(0, 15);
			for (int k = 0; k < PH_ITEMS[ph]; k++) begin
				if ($urandom_range(0, 149) == 0)
					drain_reports();
				random_item();
			end
		end

		drain_reports();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d items (%0d rejected, %0d ticks) over %0d register settings",
			n_items, n_rejected, n_ticks, n_settings);
		if (err_count == 0 && pending_reports.size() == 0)
			$display("multichannel_slew_limiter verification clean");
		else
			$display("multichannel_slew_limiter verification failed");
		$finish;
	end

endmodule
